### sv/dla_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dla_pkg: shared types and constants for the DAG layer assignment unit
// Node and layer widths, request codes, sequencer states, lane control.
// ----------------------------------------------------------------------------
package dla_pkg;

   localparam int MAX_NODES = 64;
   localparam int NODE_W    = 6;   // node index width
   localparam int CNT_W     = 7;   // 0..MAX_NODES
   localparam int LAYER_W   = 6;

   localparam logic [1:0] MODE_ADD_EDGE = 2'd0;
   localparam logic [1:0] MODE_CLEAR    = 2'd1;
   localparam logic [1:0] MODE_COMPUTE  = 2'd2;
   localparam logic [1:0] MODE_NONE     = 2'd3;

   typedef enum logic [8:0] {
      ST_IDLE    = 9'b000000001,
      ST_EDGE    = 9'b000000010,
      ST_CNT     = 9'b000000100,
      ST_SEED    = 9'b000001000,
      ST_PUSH    = 9'b000010000,
      ST_POP_Q   = 9'b000100000,
      ST_POP_ROW = 9'b001000000,
      ST_POP_UPD = 9'b010000000,
      ST_EMIT    = 9'b100000000
   } dla_state_type;

   // control for the in-degree counter lanes
   typedef struct packed {
      logic clr;   // zero every lane
      logic acc;   // add the row bits (column count)
      logic dec;   // release: decrement lanes hit by the row
   } dla_lane_ctrl_type;

endpackage

### sv/dla_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dla_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module dla_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/dla_indeg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dla_indeg: in-degree counter lanes
// One counter per node; counts column bits, then decrements on release.
// ----------------------------------------------------------------------------
module dla_indeg
   import dla_pkg::*;
(
   input  logic                  clock,
   input  dla_lane_ctrl_type     ctrl,
   input  logic [MAX_NODES-1:0]  row,
   output logic [MAX_NODES-1:0]  zero_mask,
   output logic [MAX_NODES-1:0]  rel_mask
);

   logic [CNT_W-1:0] cnt_ff [MAX_NODES];

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_NODES; i++) begin
         if (ctrl.clr) begin
            cnt_ff[i] <= '0;
         end else if (ctrl.acc) begin
            cnt_ff[i] <= cnt_ff[i] + CNT_W'(row[i]);
         end else if (ctrl.dec && row[i] && (cnt_ff[i] != '0)) begin
            cnt_ff[i] <= cnt_ff[i] - CNT_W'(1);
         end
      end
   end

   // a lane at one that the row hits reaches zero on this release
   always_comb begin
      for (int i = 0; i < MAX_NODES; i++) begin
         zero_mask[i] = (cnt_ff[i] == '0);
         rel_mask[i]  = row[i] && (cnt_ff[i] == CNT_W'(1));
      end
   end

endmodule

### sv/dag_layer_assignment_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dag_layer_assignment_unit: topological layering of a small directed graph
// Adjacency bit matrix in RAM, Kahn breadth-first release with a ready queue,
// one layer beat per node on the response channel.
// ----------------------------------------------------------------------------
//
//  channel | ports                                  | handshake
//  --------+----------------------------------------+---------------------------
//  request | req_mode, req_from_node, req_to_node   | start && !busy
//  result  | rsp_node_index, rsp_layer, rsp_last    | rsp_strobe, one cycle each
//  config  | csr_node_count                         | csr_valid && csr_ready
//
//  Add edge: row read, then row write back. Clear graph does not raise busy.
//  Compute over n nodes holds busy after the accept through the count phase (one
//  row per node), a seed step, a queue push per ready node, a pop per queued node
//  (queue read, row/layer read, release, queue check), a final check, then n emits.
//  Reset clears the graph (row valid bits) and the sequencer; node_count = 1.
//  No stalls: one rsp beat per emit cycle, the last one in the same cycle as busy drops.
//
module dag_layer_assignment_unit
   import dla_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   // request
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_mode,
   input  logic [NODE_W-1:0]  req_from_node,
   input  logic [NODE_W-1:0]  req_to_node,
   // result
   output logic               rsp_strobe,
   output logic [NODE_W-1:0]  rsp_node_index,
   output logic [LAYER_W-1:0] rsp_layer,
   output logic               rsp_last,
   // config
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [CNT_W-1:0]   csr_node_count
);

   dla_state_type        state_ff, state_in;
   logic [CNT_W-1:0]     node_count_ff;
   logic [CNT_W-1:0]     n_ff, n_in;          // clamped node count for this run
   logic [CNT_W-1:0]     ctr_ff, ctr_in;      // row counter / emit counter
   logic [MAX_NODES-1:0] row_vld_ff, row_vld_in;
   logic [MAX_NODES-1:0] written_ff, written_in;
   logic [MAX_NODES-1:0] pend_ff, pend_in;    // nodes waiting to be queued
   logic [LAYER_W-1:0]   push_layer_ff, push_layer_in;
   logic [CNT_W-1:0]     head_ff, head_in;
   logic [CNT_W-1:0]     tail_ff, tail_in;
   logic [NODE_W-1:0]    edge_from_ff, edge_from_in;
   logic [NODE_W-1:0]    edge_to_ff, edge_to_in;
   logic                 rd_vld_ff, rd_vld_in;
   logic                 cnt_v_ff, cnt_v_in;
   logic                 emit_v_ff, emit_v_in;
   logic [NODE_W-1:0]    emit_idx_ff, emit_idx_in;
   logic                 emit_last_ff, emit_last_in;
   logic                 emit_wr_ff, emit_wr_in;

   // adjacency RAM
   logic                 adj_we, adj_re;
   logic [NODE_W-1:0]    adj_waddr, adj_raddr;
   logic [MAX_NODES-1:0] adj_wdata, adj_rdata;
   // ready queue RAM
   logic                 q_we, q_re;
   logic [NODE_W-1:0]    q_wdata, q_rdata;
   // layer RAM
   logic                 lay_we, lay_re;
   logic [NODE_W-1:0]    lay_raddr;
   logic [LAYER_W-1:0]   lay_rdata;

   dla_lane_ctrl_type    lane_ctrl;
   logic [MAX_NODES-1:0] zero_mask, rel_mask;
   logic [MAX_NODES-1:0] active_mask, row_raw, row_act;
   logic [NODE_W-1:0]    pend_idx;
   logic                 accept;

   assign accept    = start && !busy;
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   // rows never written since the last clear read as zero
   assign row_raw = rd_vld_ff ? adj_rdata : '0;
   assign row_act = row_raw & active_mask;

   always_comb begin
      for (int i = 0; i < MAX_NODES; i++) begin
         active_mask[i] = (CNT_W'(i) < n_ff);
      end
   end

   // lowest pending node goes first
   always_comb begin
      pend_idx = '0;
      for (int i = MAX_NODES - 1; i >= 0; i--) begin
         if (pend_ff[i]) begin
            pend_idx = NODE_W'(i);
         end
      end
   end

   dla_ram #(.WIDTH(MAX_NODES), .DEPTH(MAX_NODES)) u_adj_ram (
      .clock   (clock),
      .wr_en   (adj_we),
      .wr_addr (adj_waddr),
      .wr_data (adj_wdata),
      .rd_en   (adj_re),
      .rd_addr (adj_raddr),
      .rd_data (adj_rdata)
   );

   dla_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_queue_ram (
      .clock   (clock),
      .wr_en   (q_we),
      .wr_addr (tail_ff[NODE_W-1:0]),
      .wr_data (q_wdata),
      .rd_en   (q_re),
      .rd_addr (head_ff[NODE_W-1:0]),
      .rd_data (q_rdata)
   );

   dla_ram #(.WIDTH(LAYER_W), .DEPTH(MAX_NODES)) u_layer_ram (
      .clock   (clock),
      .wr_en   (lay_we),
      .wr_addr (pend_idx),
      .wr_data (push_layer_ff),
      .rd_en   (lay_re),
      .rd_addr (lay_raddr),
      .rd_data (lay_rdata)
   );

   dla_indeg u_indeg (
      .clock     (clock),
      .ctrl      (lane_ctrl),
      .row       (row_act),
      .zero_mask (zero_mask),
      .rel_mask  (rel_mask)
   );

   // sequencer
   always_comb begin
      state_in      = state_ff;
      n_in          = n_ff;
      ctr_in        = ctr_ff;
      row_vld_in    = row_vld_ff;
      written_in    = written_ff;
      pend_in       = pend_ff;
      push_layer_in = push_layer_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      edge_from_in  = edge_from_ff;
      edge_to_in    = edge_to_ff;
      rd_vld_in     = rd_vld_ff;
      cnt_v_in      = 1'b0;
      emit_v_in     = 1'b0;
      emit_idx_in   = emit_idx_ff;
      emit_last_in  = emit_last_ff;
      emit_wr_in    = emit_wr_ff;

      adj_we    = 1'b0;
      adj_waddr = edge_from_ff;
      adj_wdata = row_raw | (MAX_NODES'(1) << edge_to_ff);
      adj_re    = 1'b0;
      adj_raddr = req_from_node;
      q_we      = 1'b0;
      q_wdata   = pend_idx;
      q_re      = 1'b0;
      lay_we    = 1'b0;
      lay_re    = 1'b0;
      lay_raddr = ctr_ff[NODE_W-1:0];
      lane_ctrl = '{clr: 1'b0, acc: cnt_v_ff, dec: 1'b0};

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_mode)
                  MODE_ADD_EDGE: begin
                     if (({1'b0, req_from_node} < CNT_W'(MAX_NODES)) &&
                         ({1'b0, req_to_node} < CNT_W'(MAX_NODES))) begin
                        adj_re       = 1'b1;
                        rd_vld_in    = row_vld_ff[req_from_node];
                        edge_from_in = req_from_node;
                        edge_to_in   = req_to_node;
                        state_in     = ST_EDGE;
                     end
                  end
                  MODE_CLEAR: begin
                     row_vld_in = '0;
                  end
                  MODE_COMPUTE: begin
                     if (node_count_ff == '0) begin
                        n_in = CNT_W'(1);
                     end else if (node_count_ff > CNT_W'(MAX_NODES)) begin
                        n_in = CNT_W'(MAX_NODES);
                     end else begin
                        n_in = node_count_ff;
                     end
                     lane_ctrl.clr = 1'b1;
                     ctr_in        = '0;
                     state_in      = ST_CNT;
                  end
                  MODE_NONE: begin
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_EDGE: begin
            adj_we                   = 1'b1;
            row_vld_in[edge_from_ff] = 1'b1;
            state_in                 = ST_IDLE;
         end
         ST_CNT: begin
            // one row read per cycle; the lanes add each row in the cycle after its read
            if (ctr_ff < n_ff) begin
               adj_re    = 1'b1;
               adj_raddr = ctr_ff[NODE_W-1:0];
               rd_vld_in = row_vld_ff[ctr_ff[NODE_W-1:0]];
               cnt_v_in  = 1'b1;
               ctr_in    = ctr_ff + CNT_W'(1);
            end else begin
               state_in = ST_SEED;
            end
         end
         ST_SEED: begin
            pend_in       = zero_mask & active_mask;
            push_layer_in = '0;
            head_in       = '0;
            tail_in       = '0;
            written_in    = '0;
            state_in      = ST_PUSH;
         end
         ST_PUSH: begin
            if (pend_ff != '0) begin
               q_we                 = 1'b1;
               lay_we               = 1'b1;
               written_in[pend_idx] = 1'b1;
               pend_in[pend_idx]    = 1'b0;
               tail_in              = tail_ff + CNT_W'(1);
            end else if (head_ff < tail_ff) begin
               state_in = ST_POP_Q;
            end else begin
               ctr_in   = '0;
               state_in = ST_EMIT;
            end
         end
         ST_POP_Q: begin
            q_re     = 1'b1;
            head_in  = head_ff + CNT_W'(1);
            state_in = ST_POP_ROW;
         end
         ST_POP_ROW: begin
            adj_re    = 1'b1;
            adj_raddr = q_rdata;
            rd_vld_in = row_vld_ff[q_rdata];
            lay_re    = 1'b1;
            lay_raddr = q_rdata;
            state_in  = ST_POP_UPD;
         end
         ST_POP_UPD: begin
            // successors reaching zero take the popped node's layer plus one
            lane_ctrl.dec = 1'b1;
            pend_in       = rel_mask;
            push_layer_in = lay_rdata + LAYER_W'(1);
            state_in      = ST_PUSH;
         end
         ST_EMIT: begin
            lay_re       = 1'b1;
            emit_v_in    = 1'b1;
            emit_idx_in  = ctr_ff[NODE_W-1:0];
            emit_last_in = (ctr_ff == n_ff - CNT_W'(1));
            emit_wr_in   = written_ff[ctr_ff[NODE_W-1:0]];
            ctr_in       = ctr_ff + CNT_W'(1);
            if (ctr_ff == n_ff - CNT_W'(1)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         node_count_ff <= CNT_W'(1);
         row_vld_ff    <= '0;
         cnt_v_ff      <= 1'b0;
         emit_v_ff     <= 1'b0;
      end else begin
         state_ff   <= state_in;
         row_vld_ff <= row_vld_in;
         cnt_v_ff   <= cnt_v_in;
         emit_v_ff  <= emit_v_in;
         if (csr_valid && csr_ready) begin
            node_count_ff <= csr_node_count;
         end
      end
   end

   always_ff @(posedge clock) begin
      n_ff          <= n_in;
      ctr_ff        <= ctr_in;
      written_ff    <= written_in;
      pend_ff       <= pend_in;
      push_layer_ff <= push_layer_in;
      head_ff       <= head_in;
      tail_ff       <= tail_in;
      edge_from_ff  <= edge_from_in;
      edge_to_ff    <= edge_to_in;
      rd_vld_ff     <= rd_vld_in;
      emit_idx_ff   <= emit_idx_in;
      emit_last_ff  <= emit_last_in;
      emit_wr_ff    <= emit_wr_in;
   end

   // nodes never released this run report layer zero
   assign rsp_strobe     = emit_v_ff;
   assign rsp_node_index = emit_idx_ff;
   assign rsp_layer      = emit_wr_ff ? lay_rdata : '0;
   assign rsp_last       = emit_last_ff;

endmodule
